// ----- design/iafmt_pkg.sv -----
// Package for the integer-to-ASCII formatter: conversion and length codes,
// the queued word layout and ASCII constants. No dependencies.

package iafmt_pkg;

   // conversion codes
   localparam logic [3:0] CONV_CHAR     = 4'd0;
   localparam logic [3:0] CONV_DEC      = 4'd1;
   localparam logic [3:0] CONV_DEC_LONG = 4'd2;
   localparam logic [3:0] CONV_OCT      = 4'd3;
   localparam logic [3:0] CONV_OCT_LONG = 4'd4;
   localparam logic [3:0] CONV_HEX_LOW  = 4'd5;
   localparam logic [3:0] CONV_HEX_UP   = 4'd6;
   localparam logic [3:0] CONV_UNS      = 4'd7;
   localparam logic [3:0] CONV_UNS_LONG = 4'd8;
   localparam logic [3:0] CONV_PTR      = 4'd9;

   // length modifier codes
   localparam logic [1:0] LEN_INT = 2'd0;
   localparam logic [1:0] LEN_HH  = 2'd1;
   localparam logic [1:0] LEN_H   = 2'd2;
   localparam logic [1:0] LEN_L   = 2'd3;

   localparam int VALUE_W      = 64;
   localparam int NUM_SLOTS    = 22;  // digit slots, enough for 64-bit octal
   localparam int BCD_DIGITS   = 20;  // enough for 2^64 - 1 in decimal
   localparam int DABBLE_BITS  = 8;   // binary bits folded into BCD per cycle
   localparam int DABBLE_STEPS = VALUE_W / DABBLE_BITS;
   localparam int IAF_QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] LOWER_OFS = 8'h57;  // 'a' - 10
   localparam logic [7:0] UPPER_OFS = 8'h37;  // 'A' - 10

   typedef enum logic [1:0] {
      BASE_OCT,
      BASE_DEC,
      BASE_HEX
   } base_type;

   typedef struct packed {
      logic                 is_char;
      base_type             base;
      logic                 upper;
      logic                 neg;
      logic                 ptr;
      logic [VALUE_W-1:0]   mag;
   } iafmt_entry_type;

endpackage

// ----- design/integer_to_ascii_formatter_core.sv -----
// Top level of the integer-to-ASCII formatter: front, queue and back.
// Uses iafmt_pkg, iafmt_front, iafmt_queue and iafmt_back.

// Usage
//   Request side looks like a queue: drive req_conversion, req_length_mode and
//   req_value with push; the word is taken on a rising edge with push high and
//   full low. Unknown conversion codes are taken and produce no text.
//   Result side looks like a queue: while empty is low, rsp_char_out holds the
//   oldest character (most significant first) and rsp_last marks the final
//   character of a conversion; pop takes it.
//   Flow and rate: the front classifies in the accept cycle and parks the
//   word in a QUEUE_DEPTH-entry queue. The back handles one word at a time:
//   it fetches the word, runs shift-and-add-3 for decimal (eight bits a
//   step), finds the leading digit, then sends one character per cycle while
//   the receiver keeps popping; a char goes straight to output. 22 characters
//   is the longest text. The back's single conversion datapath sets this rate.
//   A stalled receiver holds the output register; the back then waits, the
//   queue fills and full rises. Reset empties the queue and the output stage.

module integer_to_ascii_formatter_core
   import iafmt_pkg::*;
#(
   parameter int QUEUE_DEPTH = IAF_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [3:0]          req_conversion,
   input  logic [1:0]          req_length_mode,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                empty,
   input  logic                pop,
   output logic [7:0]          rsp_char_out,
   output logic                rsp_last
);

   iafmt_entry_type front_entry;
   iafmt_entry_type back_entry;
   logic            q_push;
   logic            q_pop;
   logic            q_empty;

   // decode and classify the request
   iafmt_front u_front (
      .push            (push),
      .req_conversion  (req_conversion),
      .req_length_mode (req_length_mode),
      .req_value       (req_value),
      .q_full          (full),
      .q_push          (q_push),
      .q_entry         (front_entry)
   );

   // hold classified words while the back is busy
   iafmt_queue #(
      .WIDTH ($bits(iafmt_entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (front_entry),
      .rd_en   (q_pop),
      .rd_data (back_entry),
      .full    (full),
      .empty   (q_empty)
   );

   // convert and stream characters
   iafmt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_entry      (back_entry),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .pop          (pop),
      .empty        (empty),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

endmodule

// ----- design/iafmt_queue.sv -----
// Small register FIFO between the front and back of the formatter.
// Generic width and power-of-two depth; no package dependency.

module iafmt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- design/iafmt_front.sv -----
// Front of the formatter: decode a request, truncate or sign-extend the value,
// form magnitude and sign, and queue the word. Uses iafmt_pkg.

module iafmt_front
   import iafmt_pkg::*;
(
   input  logic                 push,
   input  logic [3:0]           req_conversion,
   input  logic [1:0]           req_length_mode,
   input  logic [VALUE_W-1:0]   req_value,
   input  logic                 q_full,
   output logic                 q_push,
   output iafmt_entry_type      q_entry
);

   logic [VALUE_W-1:0] mask;
   logic [VALUE_W-1:0] trunc;
   logic [VALUE_W-1:0] sext;
   logic [VALUE_W-1:0] signed_val;
   logic               sign_bit;
   logic               known_conv;

   always_comb begin
      case (req_length_mode)
         LEN_HH: begin
            mask     = VALUE_W'(64'hFF);
            sign_bit = req_value[7];
         end
         LEN_H: begin
            mask     = VALUE_W'(64'hFFFF);
            sign_bit = req_value[15];
         end
         LEN_L: begin
            mask     = '1;
            sign_bit = req_value[VALUE_W-1];
         end
         default: begin
            mask     = VALUE_W'(64'hFFFF_FFFF);
            sign_bit = req_value[31];
         end
      endcase
      trunc = req_value & mask;
      sext  = sign_bit ? (trunc | ~mask) : trunc;
   end

   always_comb begin
      q_entry         = '0;
      q_entry.base    = BASE_DEC;
      known_conv      = 1'b1;
      signed_val      = (req_conversion == CONV_DEC_LONG) ? req_value : sext;
      case (req_conversion)
         CONV_CHAR: begin
            q_entry.is_char = 1'b1;
            q_entry.mag     = {{(VALUE_W-8){1'b0}}, req_value[7:0]};
         end
         CONV_DEC, CONV_DEC_LONG: begin
            q_entry.neg = signed_val[VALUE_W-1];
            q_entry.mag = signed_val[VALUE_W-1] ? (~signed_val + 1'b1) : signed_val;
         end
         CONV_OCT: begin
            q_entry.base = BASE_OCT;
            q_entry.mag  = trunc;
         end
         CONV_OCT_LONG: begin
            q_entry.base = BASE_OCT;
            q_entry.mag  = req_value;
         end
         CONV_HEX_LOW: begin
            q_entry.base = BASE_HEX;
            q_entry.mag  = trunc;
         end
         CONV_HEX_UP: begin
            q_entry.base  = BASE_HEX;
            q_entry.upper = 1'b1;
            q_entry.mag   = trunc;
         end
         CONV_UNS: begin
            q_entry.mag = trunc;
         end
         CONV_UNS_LONG: begin
            q_entry.mag = req_value;
         end
         CONV_PTR: begin
            q_entry.base = BASE_HEX;
            q_entry.ptr  = 1'b1;
            q_entry.mag  = req_value;
         end
         default: begin
            known_conv = 1'b0;
         end
      endcase
   end

   // unknown codes are taken and dropped: they produce no text
   assign q_push = push && !q_full && known_conv;

endmodule

// ----- design/iafmt_back.sv -----
// Back of the formatter: turn a queued word into digit slots (BCD for decimal),
// skip leading zeros, send a character a cycle unless stalled. Uses iafmt_pkg.

module iafmt_back
   import iafmt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  iafmt_entry_type   q_entry,
   input  logic              q_empty,
   output logic              q_pop,
   input  logic              pop,
   output logic              empty,
   output logic [7:0]        rsp_char_out,
   output logic              rsp_last
);

   localparam int IDX_W  = $clog2(NUM_SLOTS);
   localparam int STEP_W = $clog2(DABBLE_STEPS);
   localparam int BCD_W  = BCD_DIGITS * 4;
   localparam int PAD_W  = NUM_SLOTS * 4;

   typedef logic [NUM_SLOTS-1:0][3:0] digits_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BCD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   iafmt_entry_type    ent_ff, ent_in;
   digits_type         digits_ff, digits_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [1:0]         pre_ff, pre_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_char_ff, out_char_in;
   logic               out_last_ff, out_last_in;

   logic [BCD_W-1:0]   bcd_next;
   logic [VALUE_W-1:0] bin_next;
   logic [IDX_W-1:0]   lead;
   logic [3:0]         cur_digit;
   logic               slot_free;

   // Spread a binary value over the digit slots, slot 0 most significant.
   function automatic digits_type load_digits(input logic [VALUE_W-1:0] mag,
                                              input base_type base);
      logic [PAD_W-1:0] w;
      digits_type       d;
      w = {{(PAD_W-VALUE_W){1'b0}}, mag};
      d = '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         case (base)
            BASE_OCT: d[NUM_SLOTS-1-k] = {1'b0, w[3*k +: 3]};
            BASE_HEX: d[NUM_SLOTS-1-k] = w[4*k +: 4];
            default:  d[NUM_SLOTS-1-k] = 4'd0;
         endcase
      end
      return d;
   endfunction

   function automatic digits_type bcd_digits(input logic [BCD_W-1:0] b);
      logic [PAD_W-1:0] w;
      digits_type       d;
      w = {{(PAD_W-BCD_W){1'b0}}, b};
      d = '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         d[NUM_SLOTS-1-k] = w[4*k +: 4];
      end
      return d;
   endfunction

   // Shift-and-add-3 over DABBLE_BITS input bits.
   always_comb begin
      bcd_next = bcd_ff;
      bin_next = bin_ff;
      for (int s = 0; s < DABBLE_BITS; s++) begin
         for (int j = 0; j < BCD_DIGITS; j++) begin
            if (bcd_next[4*j +: 4] >= 4'd5) begin
               bcd_next[4*j +: 4] = bcd_next[4*j +: 4] + 4'd3;
            end
         end
         bcd_next = {bcd_next[BCD_W-2:0], bin_next[VALUE_W-1]};
         bin_next = {bin_next[VALUE_W-2:0], 1'b0};
      end
   end

   // First nonzero slot; the last slot when the value is zero.
   always_comb begin
      lead = IDX_W'(NUM_SLOTS - 1);
      for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
         if (digits_ff[k] != 4'd0) begin
            lead = IDX_W'(k);
         end
      end
   end

   assign cur_digit = digits_ff[idx_ff];
   assign slot_free = !out_valid_ff || pop;

   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      digits_in    = digits_ff;
      bcd_in       = bcd_ff;
      bin_in       = bin_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      pre_in       = pre_ff;
      out_valid_in = out_valid_ff && !pop;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               ent_in    = q_entry;
               digits_in = load_digits(q_entry.mag, q_entry.base);
               bin_in    = q_entry.mag;
               bcd_in    = '0;
               step_in   = '0;
               pre_in    = q_entry.ptr ? 2'd2 : (q_entry.neg ? 2'd1 : 2'd0);
               if (q_entry.is_char) begin
                  state_in = ST_EMIT;
               end else if (q_entry.base == BASE_DEC) begin
                  state_in = ST_BCD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_BCD: begin
            bcd_in  = bcd_next;
            bin_in  = bin_next;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DABBLE_STEPS - 1)) begin
               digits_in = bcd_digits(bcd_next);
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in   = lead;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b0;
               if (ent_ff.is_char) begin
                  out_char_in = ent_ff.mag[7:0];
                  out_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end else if (pre_ff != 2'd0) begin
                  if (ent_ff.ptr) begin
                     out_char_in = (pre_ff == 2'd2) ? CH_ZERO : CH_X;
                  end else begin
                     out_char_in = CH_MINUS;
                  end
                  pre_in = pre_ff - 1'b1;
               end else begin
                  if (cur_digit < 4'd10) begin
                     out_char_in = CH_ZERO + {4'd0, cur_digit};
                  end else if (ent_ff.upper) begin
                     out_char_in = UPPER_OFS + {4'd0, cur_digit};
                  end else begin
                     out_char_in = LOWER_OFS + {4'd0, cur_digit};
                  end
                  idx_in = idx_ff + 1'b1;
                  if (idx_ff == IDX_W'(NUM_SLOTS - 1)) begin
                     out_last_in = 1'b1;
                     state_in    = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      ent_ff      <= ent_in;
      digits_ff   <= digits_in;
      bcd_ff      <= bcd_in;
      bin_ff      <= bin_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      pre_ff      <= pre_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign empty        = !out_valid_ff;
   assign rsp_char_out = out_char_ff;
   assign rsp_last     = out_last_ff;

endmodule
